### design/nit_pkg.sv
// Shared constants and types for the normal inverse-transpose transform.
package nit_pkg;

    localparam int MatrixFracBitsDefault = 12;
    localparam int ElemW  = 16;
    localparam int RegW   = 48;
    localparam int CofW   = 33;
    localparam int VecW   = 50;
    localparam int MagW   = 49;
    localparam int NormW  = 30;
    localparam int SumW   = 62;
    localparam int RootW  = 31;
    localparam int QuoW   = 15;
    localparam int QOne   = 16384;
    localparam int ShW    = 6;

    localparam logic [1:0] CfgCol0 = 2'd0;
    localparam logic [1:0] CfgCol1 = 2'd1;
    localparam logic [1:0] CfgCol2 = 2'd2;

    localparam logic [RegW-1:0] ResetCol0 = 48'h0000_0000_1000;
    localparam logic [RegW-1:0] ResetCol1 = 48'h0000_1000_0000;
    localparam logic [RegW-1:0] ResetCol2 = 48'h1000_0000_0000;

    typedef struct packed {
        logic                   valid;
        logic                   sing;
        logic [2:0]             neg;
        logic [2:0][NormW-1:0]  mag;
    } t_norm_ctl;

endpackage

### design/normal_inverse_transpose_transform.sv
// Top level of the normal inverse-transpose transform with renormalization.
// Usage: write matrix columns on the config channel (i_cfg_valid/o_cfg_ready,
// index 0..2, 48-bit data) only while idle; index above two is ignored.
// Pulse i_start with a normal; o_busy is always low, so one word enters each
// cycle. Each word gives one result on o_out_* with o_singular, flagged by
// o_done for one cycle. The receiver cannot stall; results are never held.
// Pipeline: 5 capture, product, sum, select and magnitude stages, 1 shift
// stage, 2 square stages, 31 square-root stages (one bit each), 17 division
// stages (dividend setup, then one quotient bit each, three lanes) and 1 output
// stage. Throughput is one word per cycle. Reset clears all valid bits and loads
// the identity matrix. A singular matrix normalizes the input instead.
// A zero vector yields a zero result.
//
//
module normal_inverse_transpose_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic        o_done,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic        o_singular
);

    localparam int CW = nit_pkg::CofW;
    localparam int VW = nit_pkg::VecW;
    localparam int MW = nit_pkg::MagW;
    localparam int NW = nit_pkg::NormW;

    logic [47:0] r_col[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= nit_pkg::ResetCol0;
            r_col[1] <= nit_pkg::ResetCol1;
            r_col[2] <= nit_pkg::ResetCol2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nit_pkg::CfgCol0: r_col[0] <= i_cfg_data;
                nit_pkg::CfgCol1: r_col[1] <= i_cfg_data;
                nit_pkg::CfgCol2: r_col[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    logic signed [15:0] m[9];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m[i]   = r_col[0][16*i +: 16];
            m[3+i] = r_col[1][16*i +: 16];
            m[6+i] = r_col[2][16*i +: 16];
        end
    end

    // stage 1: cofactors from config (static between items)
    logic signed [CW-1:0] r_c[9];
    always_ff @(posedge i_clk) begin
        r_c[0] <= CW'(m[4]*m[8]) - CW'(m[5]*m[7]);
        r_c[1] <= CW'(m[2]*m[7]) - CW'(m[1]*m[8]);
        r_c[2] <= CW'(m[1]*m[5]) - CW'(m[2]*m[4]);
        r_c[3] <= CW'(m[5]*m[6]) - CW'(m[3]*m[8]);
        r_c[4] <= CW'(m[0]*m[8]) - CW'(m[2]*m[6]);
        r_c[5] <= CW'(m[2]*m[3]) - CW'(m[0]*m[5]);
        r_c[6] <= CW'(m[3]*m[7]) - CW'(m[4]*m[6]);
        r_c[7] <= CW'(m[1]*m[6]) - CW'(m[0]*m[7]);
        r_c[8] <= CW'(m[0]*m[4]) - CW'(m[1]*m[3]);
    end

    // det terms (products registered, then summed); also static
    logic signed [VW-1:0] r_dp[3];
    logic signed [VW-1:0] r_det;
    always_ff @(posedge i_clk) begin
        r_dp[0] <= VW'(m[0] * r_c[0]);
        r_dp[1] <= VW'(m[3] * r_c[1]);
        r_dp[2] <= VW'(m[6] * r_c[2]);
        r_det   <= r_dp[0] + r_dp[1] + r_dp[2];
    end

    // item path: p1 capture, p2 products, p3 sums, p4 select/negate, p5 magnitudes
    logic [4:0]           r_v;
    logic signed [15:0]   r_n1[3];
    logic signed [VW-1:0] r_pr[9];
    logic signed [15:0]   r_n2[3];
    logic signed [VW-1:0] r_s3[3];
    logic signed [15:0]   r_n3[3];
    logic signed [VW-1:0] r_s4[3];
    logic                 r_sg4;
    logic [2:0][MW-1:0]   r_a5;
    logic [2:0]           r_ng5;
    logic                 r_sg5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_start};
        end
        r_n1[0] <= i_normal_x;
        r_n1[1] <= i_normal_y;
        r_n1[2] <= i_normal_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_pr[3*i+j] <= VW'(r_n1[j] * r_c[3*i+j]);
            end
            r_n2[i] <= r_n1[i];
            r_s3[i] <= r_pr[3*i] + r_pr[3*i+1] + r_pr[3*i+2];
            r_n3[i] <= r_n2[i];
            if (r_det == '0) begin
                r_s4[i] <= VW'(r_n3[i]);
            end else if (r_det < 0) begin
                r_s4[i] <= -r_s3[i];
            end else begin
                r_s4[i] <= r_s3[i];
            end
        end
        r_sg4 <= (r_det == '0);
        r_sg5 <= r_sg4;
        for (int i = 0; i < 3; i++) begin
            r_ng5[i] <= r_s4[i][VW-1];
            r_a5[i]  <= r_s4[i][VW-1] ? MW'(-r_s4[i]) : MW'(r_s4[i]);
        end
    end

    // shift stage: leading-one position of OR of magnitudes
    logic [MW-1:0] n_or;
    logic [nit_pkg::ShW-1:0] n_lz;
    nit_pkg::t_norm_ctl r_nc;
    always_comb begin
        n_or = r_a5[0] | r_a5[1] | r_a5[2];
        n_lz = '0;
        for (int b = 0; b < MW; b++) begin
            if (n_or[b]) n_lz = nit_pkg::ShW'(b);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc.valid <= 1'b0;
        end else begin
            r_nc.valid <= r_v[4];
        end
        r_nc.sing <= r_sg5;
        r_nc.neg  <= r_ng5;
        for (int i = 0; i < 3; i++) begin
            if (n_lz >= nit_pkg::ShW'(NW-1)) begin
                r_nc.mag[i] <= NW'(r_a5[i] >> (n_lz - nit_pkg::ShW'(NW-1)));
            end else begin
                r_nc.mag[i] <= NW'(r_a5[i] << (nit_pkg::ShW'(NW-1) - n_lz));
            end
        end
    end

    logic [15:0] n_x, n_y, n_z;
    nit_normalize u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_nc),
        .o_valid (o_done),
        .o_sing  (o_singular),
        .o_x     (n_x),
        .o_y     (n_y),
        .o_z     (n_z)
    );
    assign o_out_x = n_x;
    assign o_out_y = n_y;
    assign o_out_z = n_z;

endmodule

### design/nit_normalize.sv
// Pipelined vector normalizer: square sum, square root and three divisions, one bit a stage.
module nit_normalize (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nit_pkg::t_norm_ctl     i_ctl,
    output logic                   o_valid,
    output logic                   o_sing,
    output logic [nit_pkg::ElemW-1:0] o_x,
    output logic [nit_pkg::ElemW-1:0] o_y,
    output logic [nit_pkg::ElemW-1:0] o_z
);

    localparam int NW = nit_pkg::NormW;
    localparam int SW = nit_pkg::SumW;
    localparam int RW = nit_pkg::RootW;
    localparam int QW = nit_pkg::QuoW;
    localparam int DW = NW + 15;
    localparam int SqSteps = RW;
    localparam int DvSteps = QW + 1;

    // squares
    logic [2:0][SW-1:0]    r_sq;
    nit_pkg::t_norm_ctl    r_sq_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_c.valid <= 1'b0;
        end else begin
            r_sq_c.valid <= i_ctl.valid;
        end
        r_sq_c.sing <= i_ctl.sing;
        r_sq_c.neg  <= i_ctl.neg;
        r_sq_c.mag  <= i_ctl.mag;
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= SW'({i_ctl.mag[i]} * {i_ctl.mag[i]});
        end
    end

    logic [SW-1:0]      r_sum;
    nit_pkg::t_norm_ctl r_sum_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_c.valid <= 1'b0;
        end else begin
            r_sum_c.valid <= r_sq_c.valid;
        end
        r_sum_c.sing <= r_sq_c.sing;
        r_sum_c.neg  <= r_sq_c.neg;
        r_sum_c.mag  <= r_sq_c.mag;
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    // square root, one result bit a stage
    logic               r_s_v   [SqSteps+1];
    logic [SW+1:0]      r_s_rem [SqSteps+1];
    logic [RW-1:0]      r_s_root[SqSteps+1];
    logic [SW-1:0]      r_s_x   [SqSteps+1];
    nit_pkg::t_norm_ctl r_s_c   [SqSteps+1];

    always_comb begin
        r_s_v[0]    = r_sum_c.valid;
        r_s_rem[0]  = '0;
        r_s_root[0] = '0;
        r_s_x[0]    = r_sum;
        r_s_c[0]    = r_sum_c;
    end

    for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
        logic [SW+1:0] n_rem;
        logic [SW+1:0] n_trial;
        always_comb begin
            n_rem   = {r_s_rem[k][SW-1:0], r_s_x[k][SW-1 -: 2]};
            n_trial = {r_s_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[k+1] <= 1'b0;
            end else begin
                r_s_v[k+1] <= r_s_v[k];
            end
            r_s_c[k+1] <= r_s_c[k];
            r_s_x[k+1] <= {r_s_x[k][SW-3:0], 2'b00};
            if (n_rem >= n_trial) begin
                r_s_rem[k+1]  <= n_rem - n_trial;
                r_s_root[k+1] <= {r_s_root[k][RW-2:0], 1'b1};
            end else begin
                r_s_rem[k+1]  <= n_rem;
                r_s_root[k+1] <= {r_s_root[k][RW-2:0], 1'b0};
            end
        end
    end

    // dividend a*16384 + r/2, restoring division one quotient bit a stage
    logic               r_d_v   [DvSteps+1];
    logic [2:0][DW:0]   r_d_rem [DvSteps+1];
    logic [2:0][QW:0]   r_d_q   [DvSteps+1];
    logic [RW-1:0]      r_d_den [DvSteps+1];
    logic               r_d_s   [DvSteps+1];
    logic [2:0]         r_d_n   [DvSteps+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else begin
            r_d_v[0] <= r_s_v[SqSteps];
        end
        r_d_den[0] <= r_s_root[SqSteps];
        r_d_s[0]   <= r_s_c[SqSteps].sing;
        r_d_n[0]   <= r_s_c[SqSteps].neg;
        for (int i = 0; i < 3; i++) begin
            r_d_rem[0][i] <= (DW+1)'({r_s_c[SqSteps].mag[i], 14'd0})
                + (DW+1)'(r_s_root[SqSteps] >> 1);
            r_d_q[0][i]   <= '0;
        end
    end

    for (genvar k = 0; k < DvSteps; k++) begin : g_div
        localparam int Sh = DvSteps - 1 - k;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k+1] <= 1'b0;
            end else begin
                r_d_v[k+1] <= r_d_v[k];
            end
            r_d_den[k+1] <= r_d_den[k];
            r_d_s[k+1]   <= r_d_s[k];
            r_d_n[k+1]   <= r_d_n[k];
            for (int i = 0; i < 3; i++) begin
                if (r_d_rem[k][i] >= ((DW+1)'(r_d_den[k]) << Sh)) begin
                    r_d_rem[k+1][i] <= r_d_rem[k][i] - ((DW+1)'(r_d_den[k]) << Sh);
                    r_d_q[k+1][i]   <= r_d_q[k][i] | ((QW+1)'(1) << Sh);
                end else begin
                    r_d_rem[k+1][i] <= r_d_rem[k][i];
                    r_d_q[k+1][i]   <= r_d_q[k][i];
                end
            end
        end
    end

    // clamp, sign, register out
    logic                         r_o_v;
    logic                         r_o_s;
    logic [2:0][nit_pkg::ElemW-1:0] r_o;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_d_v[DvSteps];
        end
        r_o_s <= r_d_s[DvSteps];
        for (int i = 0; i < 3; i++) begin
            logic [nit_pkg::ElemW-1:0] n_q;
            n_q = (r_d_den[DvSteps] == '0) ? '0 :
                  (r_d_q[DvSteps][i] > (QW+1)'(nit_pkg::QOne)) ?
                  nit_pkg::ElemW'(nit_pkg::QOne) : nit_pkg::ElemW'(r_d_q[DvSteps][i]);
            r_o[i] <= r_d_n[DvSteps][i] ? (~n_q + 1'b1) : n_q;
        end
    end

    assign o_valid = r_o_v;
    assign o_sing  = r_o_s;
    assign o_x     = r_o[0];
    assign o_y     = r_o[1];
    assign o_z     = r_o[2];

endmodule

### design/nit_checker.sv
// Port-level assertions for the normal inverse-transpose transform.
module nit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_singular,
    input logic [15:0] o_out_x,
    input logic [15:0] o_out_y,
    input logic [15:0] o_out_z
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_out_x) <= 16384 && $signed(o_out_x) >= -16384))
        else $error("x out of range");
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_out_y) <= 16384 && $signed(o_out_y) >= -16384))
        else $error("y out of range");
    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_out_z) <= 16384 && $signed(o_out_z) >= -16384))
        else $error("z out of range");
endmodule

bind normal_inverse_transpose_transform nit_checker u_nit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .o_singular (o_singular),
    .o_out_x    (o_out_x),
    .o_out_y    (o_out_y),
    .o_out_z    (o_out_z)
);
